// ===== src/sbls_pkg.sv =====
// Package for the sorted block lower-bound search.
// Holds block geometry, command, status and sequencer state types.
// Used by sorted_block_lower_bound_search; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package sbls_pkg;

   localparam int BLOCK_DEPTH = 32;
   localparam int SLOT_W      = $clog2(BLOCK_DEPTH);
   localparam int CNT_W       = $clog2(BLOCK_DEPTH + 1);

   // one stored element: docno, frequency, weight bits
   localparam int DOCNO_W = 32;
   localparam int FF_W    = 16;
   localparam int WGT_W   = 16;
   localparam int ELEM_W  = DOCNO_W + FF_W + WGT_W;

   localparam int CSR_ADDR_W = 3;

   typedef enum logic [1:0] {
      CMD_CLEAR  = 2'd0,
      CMD_APPEND = 2'd1,
      CMD_SEARCH = 2'd2,
      CMD_NOP    = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      ST_DONE      = 3'd0,
      ST_FULL      = 3'd1,
      ST_EXACT     = 3'd2,
      ST_GREATER   = 3'd3,
      ST_NOT_FOUND = 3'd4
   } status_type;

   typedef enum logic {
      SEQ_IDLE = 1'b0,
      SEQ_SCAN = 1'b1
   } seq_state_type;

   localparam logic REG_MAX_FF = 1'b0;

endpackage

`default_nettype wire

// ===== src/sbls_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module sbls_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== src/sorted_block_lower_bound_search.sv =====
// Sorted posting block with lower-bound search: top level.
// Depends on sbls_pkg and sbls_ram.
`timescale 1ns / 1ps
`default_nettype none

// A request is taken when start is high and busy is low. Clear, append and
// the unused command finish without raising busy: the response strobes
// rsp_valid on the next cycle. A search whose start_slot is at or past the
// element count also answers on the next cycle. Any other search walks the
// element RAM one slot per cycle through a single read port and one docno
// compare, from start_slot up to the first hit or the end of the stored
// elements, and holds busy until it answers. The response is on the rsp_
// ports for exactly one cycle and cannot be stalled.
module sorted_block_lower_bound_search import sbls_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   // request channel
   input  wire logic                  start,
   output logic                       busy,
   input  wire logic [1:0]            req_cmd,
   input  wire logic [31:0]           req_docno,
   input  wire logic [15:0]           req_ff_value,
   input  wire logic [15:0]           req_weight_bits,
   input  wire logic [5:0]            req_start_slot,
   // response channel
   output logic                       rsp_valid,
   output logic [2:0]                 rsp_status,
   output logic [4:0]                 rsp_found_slot,
   output logic [31:0]                rsp_found_docno,
   output logic [15:0]                rsp_found_ff,
   output logic [15:0]                rsp_found_weight,
   // register port
   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic [CSR_ADDR_W-1:0] paddr,
   input  wire logic [31:0]           pwdata,
   output logic [31:0]                prdata,
   output logic                       pready
);

   seq_state_type state_ff, state_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [CNT_W-1:0]   ptr_ff, ptr_in;
   logic [SLOT_W-1:0]  chk_slot_ff, chk_slot_in;
   logic               chk_valid_ff, chk_valid_in;
   logic [DOCNO_W-1:0] key_ff, key_in;
   logic [FF_W-1:0]    max_ff_ff;

   logic               rsp_valid_ff, rsp_valid_in;
   status_type         rsp_status_ff, rsp_status_in;
   logic [4:0]         rsp_slot_ff, rsp_slot_in;
   logic [DOCNO_W-1:0] rsp_docno_ff, rsp_docno_in;
   logic [FF_W-1:0]    rsp_ff_ff, rsp_ff_in;
   logic [WGT_W-1:0]   rsp_wgt_ff, rsp_wgt_in;

   logic               accept;
   cmd_type            cmd;
   logic               full;
   logic [FF_W-1:0]    ff_clamped;
   logic               wr_en;
   logic [ELEM_W-1:0]  wr_data;
   logic [ELEM_W-1:0]  rd_data;
   logic [SLOT_W-1:0]  rd_addr;
   logic [DOCNO_W-1:0] rd_docno;
   logic [FF_W-1:0]    rd_ff;
   logic [WGT_W-1:0]   rd_wgt;
   logic               issue;
   logic               hit;
   logic [31:0]        slot_ext;
   logic               csr_wr;

   // ---------------- register port ----------------
   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_ff_ff <= '1;
      end else if (csr_wr && paddr[2] == REG_MAX_FF) begin
         max_ff_ff <= pwdata[FF_W-1:0];
      end
   end

   always_comb begin
      prdata = '0;
      if (paddr[2] == REG_MAX_FF) begin
         prdata = {16'd0, max_ff_ff};
      end
   end

   // ---------------- element RAM ----------------
   assign accept     = start && !busy;
   assign cmd        = cmd_type'(req_cmd);
   assign full       = (count_ff == CNT_W'(BLOCK_DEPTH));
   assign ff_clamped = (req_ff_value > max_ff_ff) ? max_ff_ff : req_ff_value;
   assign wr_en      = accept && cmd == CMD_APPEND && !full;
   assign wr_data    = {req_docno, ff_clamped, req_weight_bits};
   assign rd_addr    = ptr_ff[SLOT_W-1:0];

   sbls_ram #(
      .WIDTH(ELEM_W),
      .DEPTH(BLOCK_DEPTH)
   ) u_elem_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(count_ff[SLOT_W-1:0]),
      .wr_data(wr_data),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   assign rd_docno = rd_data[ELEM_W-1 -: DOCNO_W];
   assign rd_ff    = rd_data[WGT_W +: FF_W];
   assign rd_wgt   = rd_data[WGT_W-1:0];

   // ---------------- sequencer ----------------
   // reads are issued one slot ahead of the compare
   assign issue    = (state_ff == SEQ_SCAN) && (ptr_ff < count_ff);
   assign hit      = chk_valid_ff && (rd_docno >= key_ff);
   assign slot_ext = 32'(chk_slot_ff);
   assign busy     = (state_ff != SEQ_IDLE);

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      ptr_in        = ptr_ff;
      key_in        = key_ff;
      chk_slot_in   = ptr_ff[SLOT_W-1:0];
      chk_valid_in  = 1'b0;
      rsp_valid_in  = 1'b0;
      rsp_status_in = ST_DONE;
      rsp_slot_in   = '0;
      rsp_docno_in  = '0;
      rsp_ff_in     = '0;
      rsp_wgt_in    = '0;

      case (state_ff)
         SEQ_IDLE: begin
            if (accept) begin
               case (cmd)
                  CMD_CLEAR: begin
                     count_in     = '0;
                     rsp_valid_in = 1'b1;
                  end
                  CMD_APPEND: begin
                     rsp_valid_in = 1'b1;
                     if (full) begin
                        rsp_status_in = ST_FULL;
                     end else begin
                        count_in = count_ff + CNT_W'(1);
                     end
                  end
                  CMD_SEARCH: begin
                     if (32'(req_start_slot) >= 32'(count_ff)) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = ST_NOT_FOUND;
                     end else begin
                        ptr_in   = CNT_W'(req_start_slot);
                        key_in   = req_docno;
                        state_in = SEQ_SCAN;
                     end
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end
         SEQ_SCAN: begin
            chk_valid_in = issue;
            if (issue) begin
               ptr_in = ptr_ff + CNT_W'(1);
            end
            if (hit) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = (rd_docno == key_ff) ? ST_EXACT : ST_GREATER;
               rsp_slot_in   = slot_ext[4:0];
               rsp_docno_in  = rd_docno;
               rsp_ff_in     = rd_ff;
               rsp_wgt_in    = rd_wgt;
               state_in      = SEQ_IDLE;
            end else if (!issue && !chk_valid_ff) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = ST_NOT_FOUND;
               state_in      = SEQ_IDLE;
            end
         end
         default: begin
            state_in = SEQ_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= SEQ_IDLE;
         count_ff     <= '0;
         chk_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         chk_valid_ff <= chk_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ptr_ff        <= ptr_in;
      key_ff        <= key_in;
      chk_slot_ff   <= chk_slot_in;
      rsp_status_ff <= rsp_status_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_docno_ff  <= rsp_docno_in;
      rsp_ff_ff     <= rsp_ff_in;
      rsp_wgt_ff    <= rsp_wgt_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_found_slot   = rsp_slot_ff;
   assign rsp_found_docno  = rsp_docno_ff;
   assign rsp_found_ff     = rsp_ff_ff;
   assign rsp_found_weight = rsp_wgt_ff;

endmodule

`default_nettype wire
